FILE: rtl/cartridge_bank_mapper_scanline_irq_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the cartridge bank mapper
// Shared concurrent-check forms, clocked on clk and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef CARTRIDGE_BANK_MAPPER_SCANLINE_IRQ_ASSERT_SVH
`define CARTRIDGE_BANK_MAPPER_SCANLINE_IRQ_ASSERT_SVH

// same-cycle implication
`define CBM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CBM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/cbm_pkg.sv
// ----------------------------------------------------------------------------
// cbm_pkg
// Types and constants shared by the bank mapper core and top level.
// ----------------------------------------------------------------------------
package cbm_pkg;

    // command codes
    localparam logic [2:0] CMD_WRITE = 3'd0;
    localparam logic [2:0] CMD_PRG   = 3'd1;
    localparam logic [2:0] CMD_CHR   = 3'd2;
    localparam logic [2:0] CMD_WRAM  = 3'd3;
    localparam logic [2:0] CMD_TICK  = 3'd4;

    // configuration register indexes
    localparam logic [1:0] REG_PRG_COUNT = 2'd0;
    localparam logic [1:0] REG_CHR_ROM   = 2'd1;
    localparam logic [1:0] REG_FOUR_SCR  = 2'd2;

    // mapper register decode: {address[15:13], address[0]}
    localparam logic [3:0] DEC_SELECT = 4'b1000;
    localparam logic [3:0] DEC_DATA   = 4'b1001;
    localparam logic [3:0] DEC_MIRROR = 4'b1010;
    localparam logic [3:0] DEC_LATCH  = 4'b1100;
    localparam logic [3:0] DEC_RELOAD = 4'b1101;
    localparam logic [3:0] DEC_IRQ_OFF = 4'b1110;
    localparam logic [3:0] DEC_IRQ_ON  = 4'b1111;

    localparam logic [8:0] VISIBLE_LINES = 9'd240;

    localparam int CHR_COUNT = 6;
    localparam logic [7:0] CHR_RESET [CHR_COUNT] =
        '{8'd0, 8'd2, 8'd4, 8'd5, 8'd6, 8'd7};

    localparam logic [8:0] PRG_COUNT_RESET = 9'd32;

    typedef struct packed {
        logic [8:0] prg_bank_count;
        logic       chr_rom_present;
        logic       four_screen;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] address;
        logic [7:0]  data;
        logic [8:0]  scanline;
        logic        display_on;
    } item_t;

    typedef struct packed {
        logic [7:0] bank;
        logic [7:0] read_data;
        logic       irq;
        logic       mirroring;
    } result_t;

endpackage

FILE: rtl/cbm_core.sv
// ----------------------------------------------------------------------------
// cbm_core
// Mapper state, register write decode, bank translation, work-RAM read
// transform and scanline IRQ counter. State commits when fire is high.
// ----------------------------------------------------------------------------
`include "cartridge_bank_mapper_scanline_irq_assert.svh"

module cbm_core
    import cbm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  item_t   item,
    input  logic    fire,
    output result_t result
);

    logic [7:0] bank_select_reg, bank_select_next;
    logic [7:0] chr_banks_reg [CHR_COUNT];
    logic [7:0] prg0_reg, prg0_next;
    logic [7:0] prg1_reg, prg1_next;
    logic       unprotected_reg, unprotected_next;
    logic       irq_on_reg, irq_on_next;
    logic [7:0] line_counter_reg, line_counter_next;
    logic [7:0] reload_value_reg, reload_value_next;
    logic       irq_pending_reg, irq_pending_next;
    logic       mirror_bit_reg, mirror_bit_next;

    logic       chr_we;
    logic [2:0] chr_widx;
    logic [7:0] chr_wdata;

    // register write decode
    logic [3:0] dec;
    logic       is_write;
    assign dec      = {item.address[15:13], item.address[0]};
    assign is_write = (item.cmd == CMD_WRITE) && item.address[15];

    // scanline tick
    logic       tick_act;
    logic [7:0] cnt_pre;

    assign tick_act = (item.cmd == CMD_TICK) && (item.scanline < VISIBLE_LINES)
                      && item.display_on && irq_on_reg && !irq_pending_reg;
    assign cnt_pre  = ((item.scanline == 9'd0) && (line_counter_reg != 8'd0))
                      ? line_counter_reg - 8'd1 : line_counter_reg;

    // next state
    always_comb
    begin
        bank_select_next  = bank_select_reg;
        prg0_next         = prg0_reg;
        prg1_next         = prg1_reg;
        unprotected_next  = unprotected_reg;
        irq_on_next       = irq_on_reg;
        line_counter_next = line_counter_reg;
        reload_value_next = reload_value_reg;
        irq_pending_next  = irq_pending_reg;
        mirror_bit_next   = mirror_bit_reg;
        chr_we            = 1'b0;
        chr_widx          = bank_select_reg[2:0];
        chr_wdata         = item.data;

        if (is_write)
        begin
            case (dec)
                DEC_SELECT:
                begin
                    bank_select_next = item.data;
                    unprotected_next = 1'b0;
                end
                DEC_DATA:
                begin
                    case (bank_select_reg[2:0])
                        3'd0, 3'd1:
                        begin
                            chr_we    = 1'b1;
                            chr_wdata = item.data & 8'hFE;
                        end
                        3'd6:    prg0_next = item.data;
                        3'd7:    prg1_next = item.data;
                        default: chr_we    = 1'b1;
                    endcase
                end
                DEC_MIRROR:
                begin
                    if (!cfg.four_screen)
                        mirror_bit_next = item.data[0];
                end
                DEC_LATCH:
                begin
                    line_counter_next = item.data;
                    irq_pending_next  = 1'b0;
                end
                DEC_RELOAD:
                begin
                    reload_value_next = item.data;
                    irq_pending_next  = 1'b0;
                end
                DEC_IRQ_OFF:
                begin
                    irq_on_next      = 1'b0;
                    irq_pending_next = 1'b0;
                end
                DEC_IRQ_ON:
                begin
                    irq_on_next      = 1'b1;
                    irq_pending_next = 1'b0;
                end
                default: ;
            endcase
        end
        else if (tick_act)
        begin
            if (cnt_pre == 8'd0)
            begin
                irq_pending_next  = 1'b1;
                line_counter_next = reload_value_reg;
            end
            else
            begin
                line_counter_next = cnt_pre - 8'd1;
            end
        end
    end

    // program window translate
    logic [1:0] prg_win;
    logic [7:0] last1, last2, prg_bank;
    assign prg_win = item.address[14:13];
    assign last1   = cfg.prg_bank_count[7:0] - 8'd1;
    assign last2   = cfg.prg_bank_count[7:0] - 8'd2;

    always_comb
    begin
        if (!item.address[15])
            prg_bank = 8'd0;
        else if (prg_win == 2'd3)
            prg_bank = last1;
        else if (prg_win == 2'd1)
            prg_bank = prg1_reg;
        else if ((prg_win == 2'd0) != bank_select_reg[6])
            prg_bank = prg0_reg;
        else
            prg_bank = last2;
    end

    // pattern window translate: one bank register read, +1 for odd pair half
    logic [2:0] chr_win, chr_ridx;
    logic [7:0] chr_raw, chr_sum, chr_bank;
    assign chr_win  = item.address[12:10] ^ {bank_select_reg[7], 2'b00};
    assign chr_ridx = chr_win[2] ? (chr_win - 3'd2) : {2'b00, chr_win[1]};
    assign chr_raw  = chr_banks_reg[chr_ridx];
    assign chr_sum  = chr_win[2] ? chr_raw : (chr_raw + {7'd0, chr_win[0]});

    always_comb
    begin
        if (item.address[15:13] != 3'b000)
            chr_bank = 8'd0;
        else if (!cfg.chr_rom_present)
            chr_bank = chr_sum & 8'h07;
        else
            chr_bank = chr_sum;
    end

    // result
    always_comb
    begin
        result.bank      = 8'd0;
        result.read_data = 8'd0;
        result.irq       = irq_pending_next;
        result.mirroring = mirror_bit_next;
        case (item.cmd)
            CMD_PRG: result.bank = prg_bank;
            CMD_CHR: result.bank = chr_bank;
            CMD_WRAM:
            begin
                if ((item.address[15:13] == 3'b011) && unprotected_reg)
                    result.read_data = item.data ^ 8'h01;
                else
                    result.read_data = item.data;
            end
            default: ;
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_select_reg  <= 8'd0;
            prg0_reg         <= 8'd0;
            prg1_reg         <= 8'd1;
            unprotected_reg  <= 1'b1;
            irq_on_reg       <= 1'b0;
            line_counter_reg <= 8'd0;
            reload_value_reg <= 8'd0;
            irq_pending_reg  <= 1'b0;
            mirror_bit_reg   <= 1'b0;
            for (int i = 0; i < CHR_COUNT; i++)
                chr_banks_reg[i] <= CHR_RESET[i];
        end
        else if (fire)
        begin
            bank_select_reg  <= bank_select_next;
            prg0_reg         <= prg0_next;
            prg1_reg         <= prg1_next;
            unprotected_reg  <= unprotected_next;
            irq_on_reg       <= irq_on_next;
            line_counter_reg <= line_counter_next;
            reload_value_reg <= reload_value_next;
            irq_pending_reg  <= irq_pending_next;
            mirror_bit_reg   <= mirror_bit_next;
            if (chr_we)
                chr_banks_reg[chr_widx] <= chr_wdata;
        end
    end

    // checks
    logic tick_fire, write_fire;
    assign tick_fire  = fire && (item.cmd == CMD_TICK);
    assign write_fire = fire && (item.cmd == CMD_WRITE);

    `CBM_ASSERT_NOW(a_pending_rise, $rose(irq_pending_reg), $past(tick_fire), "irq set off a tick")
    `CBM_ASSERT_NEXT(a_count_holds, !fire, $stable(line_counter_reg), "counter moved while idle")
    `CBM_ASSERT_NEXT(a_select_holds, !fire, $stable(bank_select_reg), "select moved while idle")
    `CBM_ASSERT_NOW(a_protect_wr, $fell(unprotected_reg), $past(write_fire), "protect off a write")

endmodule

FILE: rtl/cartridge_bank_mapper_scanline_irq.sv
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_scanline_irq
// Path: an item transfer is captured in the input register, then its result in the
//   result register, where it waits while result_stall is high.
// Throughput: one item per cycle while result_stall is low; the input register and
//   the result register each take a new item whenever the stage after them moves.
// Reset (rst_n, async low) clears the pipeline and restores mapper state and
//   configuration to their power-on values at once; no clearing pass.
// ----------------------------------------------------------------------------
`include "cartridge_bank_mapper_scanline_irq_assert.svh"

module cartridge_bank_mapper_scanline_irq
    import cbm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_data,
    // item channel
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [2:0]  cmd,
    input  logic [15:0] address,
    input  logic [7:0]  data,
    input  logic [8:0]  scanline,
    input  logic        display_on,
    // result channel
    output logic        result_valid,
    input  logic        result_stall,
    output logic [7:0]  bank,
    output logic [7:0]  read_data,
    output logic        irq,
    output logic        mirroring
);

    cfg_t    cfg_reg;
    logic    s1_valid_reg, s1_valid_next;
    item_t   s1_item_reg;
    logic    out_valid_reg, out_valid_next;
    result_t out_reg;
    result_t core_result;
    logic    s1_move, s1_fire, accept;
    logic    out_drain, fire_no_xlate;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prg_bank_count  <= PRG_COUNT_RESET;
            cfg_reg.chr_rom_present <= 1'b1;
            cfg_reg.four_screen     <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PRG_COUNT: cfg_reg.prg_bank_count  <= cfg_data;
                REG_CHR_ROM:   cfg_reg.chr_rom_present <= cfg_data[0];
                REG_FOUR_SCR:  cfg_reg.four_screen     <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // pipeline flow control
    assign s1_move    = !out_valid_reg || !result_stall;
    assign s1_fire    = s1_valid_reg && s1_move;
    assign item_stall = s1_valid_reg && !s1_move;
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_move)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (s1_fire)
            out_valid_next = 1'b1;
        else if (!result_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg.cmd        <= cmd;
            s1_item_reg.address    <= address;
            s1_item_reg.data       <= data;
            s1_item_reg.scanline   <= scanline;
            s1_item_reg.display_on <= display_on;
        end
    end

    cbm_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .item   (s1_item_reg),
        .fire   (s1_fire),
        .result (core_result)
    );

    // result register
    always_ff @(posedge clk)
    begin
        if (s1_fire)
            out_reg <= core_result;
    end

    assign result_valid = out_valid_reg;
    assign bank         = out_reg.bank;
    assign read_data    = out_reg.read_data;
    assign irq          = out_reg.irq;
    assign mirroring    = out_reg.mirroring;

    // checks
    assign out_drain     = out_valid_reg && !result_stall && !s1_valid_reg;
    assign fire_no_xlate = s1_fire && (s1_item_reg.cmd != CMD_PRG)
                           && (s1_item_reg.cmd != CMD_CHR);

    `CBM_ASSERT_NEXT(a_s1_held, item_stall, s1_valid_reg, "input register dropped a stalled item")
    `CBM_ASSERT_NEXT(a_out_drains, out_drain, !out_valid_reg, "result repeated after transfer")
    `CBM_ASSERT_NEXT(a_bank_zero, fire_no_xlate, out_reg.bank == 8'd0, "bank set off a translate")

endmodule
